// ===== rtl/mffd_pkg.sv =====
// ----------------------------------------------------------------------------
// mffd_pkg
// Shared types and constants of the multi-format frame detector: frame
// format codes, marker bytes, frame lengths and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package mffd_pkg;

  // register address
  localparam logic [1:0] REG_PROTO_TYPE = 2'd0;

  // frame format codes
  localparam logic [3:0] PROTO_HASH_PCT = 4'd0;
  localparam logic [3:0] PROTO_AV_CRLF  = 4'd1;
  localparam logic [3:0] PROTO_ST_16    = 4'd2;
  localparam logic [3:0] PROTO_ST_17    = 4'd3;
  localparam logic [3:0] PROTO_ST_14    = 4'd4;
  localparam logic [3:0] PROTO_PREFIX   = 4'd5;
  localparam logic [3:0] PROTO_EB90     = 4'd6;
  localparam logic [3:0] PROTO_AABB     = 4'd7;
  localparam logic [3:0] PROTO_G_CRLF   = 4'd8;

  // marker bytes
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_EB   = 8'heb;
  localparam logic [7:0] CH_90   = 8'h90;
  localparam logic [7:0] CH_FF   = 8'hff;
  localparam logic [7:0] CH_AA   = 8'haa;
  localparam logic [7:0] CH_BB   = 8'hbb;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_J    = 8'h4a;
  localparam logic [7:0] CH_O    = 8'h4f;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_V    = 8'h56;

  // frame lengths
  localparam int LEN_HASH   = 23;
  localparam int LEN_PCT    = 36;
  localparam int POS_STAR   = 19;
  localparam int LEN_AV     = 16;
  localparam int LEN_BJT    = 42;
  localparam int LEN_SOE    = 26;
  localparam int LEN_ERR    = 19;
  localparam int LEN_PREFIX = 3;
  localparam int LEN_EB90   = 38;
  localparam int LEN_AABB   = 9;
  localparam int LEN_G_LONG = 39;
  localparam int LEN_G      = 38;
  localparam int LEN_MIN    = 9;

  localparam int LW = 6;

  typedef struct packed {
    logic append;
    logic drop;
    logic rd_first;
    logic rd_next;
    logic load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic drop;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/mffd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mffd_ctrl
// Controller: sequences append, frame check and byte-wise frame emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mffd_ctrl
  import mffd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_check_now,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign in_stall = in_stall_r;
  assign accept   = in_valid && !in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.append = 1'b1;
          if (in_check_now) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.match) begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_LOAD;
        end else begin
          cmd.drop  = status.drop;
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (status.out_taken) begin
          if (status.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  a_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (state_r != S_CHECK))
    else $error("frame check held for more than one cycle");

  a_no_match_and_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> !(status.match && status.drop))
    else $error("frame check both matched and dropped");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (in_stall && state_r == S_SEND))
    else $error("load not followed by send with input stalled");

endmodule

`default_nettype wire

// ===== rtl/mffd_dp.sv =====
// ----------------------------------------------------------------------------
// mffd_dp
// Datapath: byte store, fill count, header capture, frame classifier,
// format register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mffd_dp
  import mffd_pkg::*;
#(
  parameter int BUF_DEPTH = 256
)
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  output status_t            status,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_value,
  output logic [3:0]         proto,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_frame_byte,
  output logic [LW-1:0]      out_frame_length,
  output logic               out_frame_last
);

  localparam int CW = $clog2(BUF_DEPTH);

  logic [7:0]    mem [BUF_DEPTH];

  logic [CW-1:0] count_r;
  logic [3:0]    proto_r;
  logic [7:0]    h0_r, h1_r, h2_r, h19_r, prev_r, last_r;
  logic [LW-1:0] len_r, rd_ptr_r, rd_ptr_nxt;
  logic [7:0]    rd_data_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r, out_valid_r;

  logic [CW-1:0] wr_pos;
  logic          full;
  logic          taken;
  logic          m, w, crlf, st_end, t_end;

  assign full  = (32'(count_r) >= BUF_DEPTH - 1);
  assign wr_pos = full ? '0 : count_r;
  assign taken = out_valid_r && !out_stall;
  assign rd_ptr_nxt = cmd.rd_first ? '0 : rd_ptr_r + LW'(1);

  // frame classifier on the registered fill state
  always_comb begin
    crlf   = (prev_r == CH_CR) && (last_r == CH_LF);
    st_end = (h0_r == CH_S) && (h1_r == CH_T) && (last_r == CH_A);
    t_end  = (h0_r == CH_T) && (last_r == CH_A);
    m = 1'b0;
    w = 1'b1;
    case (proto_r)
      PROTO_HASH_PCT: begin
        m = ((count_r == CW'(LEN_HASH)) && (h0_r == CH_HASH) && crlf) ||
            ((count_r == CW'(LEN_PCT)) && (h0_r == CH_PCT) && (h19_r == CH_STAR) && crlf);
        w = ((h0_r == CH_HASH) && (count_r < CW'(LEN_HASH))) ||
            ((h0_r == CH_PCT) && (count_r < CW'(LEN_PCT)));
      end
      PROTO_AV_CRLF: begin
        m = (count_r == CW'(LEN_AV)) && ((h0_r == CH_A) || (h0_r == CH_V)) && crlf;
        w = count_r < CW'(LEN_AV);
      end
      PROTO_ST_16: begin
        m = ((count_r == CW'(17)) && st_end) || ((count_r == CW'(16)) && t_end);
        w = count_r < CW'(16);
      end
      PROTO_ST_17: begin
        m = (((count_r == CW'(18)) || (count_r == CW'(22))) && st_end) ||
            (((count_r == CW'(17)) || (count_r == CW'(21))) && t_end);
        w = count_r < CW'(17);
      end
      PROTO_ST_14: begin
        m = ((count_r == CW'(15)) && st_end) || ((count_r == CW'(14)) && t_end);
        w = count_r < CW'(14);
      end
      PROTO_PREFIX: begin
        if (count_r <= CW'(LEN_PREFIX)) begin
          w = 1'b1;
        end else if ((h0_r == CH_B) && (h1_r == CH_J) && (h2_r == CH_T)) begin
          m = count_r == CW'(LEN_BJT);
          w = count_r < CW'(LEN_BJT);
        end else if ((h0_r == CH_S) && (h1_r == CH_O) && (h2_r == CH_E)) begin
          m = count_r == CW'(LEN_SOE);
          w = count_r < CW'(LEN_SOE);
        end else if ((h0_r == CH_E) && (h1_r == CH_R) && (h2_r == CH_R)) begin
          m = count_r == CW'(LEN_ERR);
          w = count_r < CW'(LEN_ERR);
        end else begin
          w = 1'b0;
        end
      end
      PROTO_EB90: begin
        m = (count_r == CW'(LEN_EB90)) && (h0_r == CH_EB) && (h1_r == CH_90) &&
            (last_r == CH_FF);
        w = count_r < CW'(LEN_EB90);
      end
      PROTO_AABB: begin
        m = (count_r == CW'(LEN_AABB)) && (h0_r == CH_AA) && (last_r == CH_BB);
        w = count_r < CW'(LEN_AABB);
      end
      PROTO_G_CRLF: begin
        m = ((count_r == CW'(LEN_G_LONG)) || (count_r == CW'(LEN_G))) &&
            (h1_r == CH_G) && crlf;
        w = count_r < CW'(LEN_G);
      end
      default: begin
        m = 1'b0;
        w = 1'b1;
      end
    endcase
  end

  assign status.match     = m;
  assign status.drop      = !m && !w;
  assign status.out_taken = taken;
  assign status.out_last  = out_last_r;

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_pos] <= in_data_byte;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_data_r <= mem[CW'(rd_ptr_nxt)];
    end
  end

  // header and tail capture, frame length, read pointer and output byte
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      prev_r <= last_r;
      last_r <= in_data_byte;
      if (wr_pos == CW'(0)) begin
        h0_r <= in_data_byte;
      end
      if (wr_pos == CW'(1)) begin
        h1_r <= in_data_byte;
      end
      if (wr_pos == CW'(2)) begin
        h2_r <= in_data_byte;
      end
      if (wr_pos == CW'(POS_STAR)) begin
        h19_r <= in_data_byte;
      end
    end
    if (cmd.rd_first) begin
      len_r <= count_r[LW-1:0];
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_ptr_r <= rd_ptr_nxt;
    end
    if (cmd.load) begin
      out_byte_r <= rd_data_r;
      out_last_r <= (rd_ptr_r == len_r - LW'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      proto_r     <= PROTO_HASH_PCT;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_value != proto_r)) begin
        proto_r <= cfg_value;
        count_r <= '0;
      end else if (cmd.append) begin
        count_r <= wr_pos + CW'(1);
      end else if (cmd.drop || cmd.finish) begin
        count_r <= '0;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign proto            = proto_r;
  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_frame_length = len_r;
  assign out_frame_last   = out_last_r;

  a_emit_with_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r >= CW'(LEN_MIN)))
    else $error("frame byte emitted with short buffer");

  a_ptr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rd_ptr_r < len_r))
    else $error("read pointer beyond frame length");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && out_last_r) |=> (!out_valid_r && count_r == '0))
    else $error("buffer not emptied after last frame byte");

endmodule

`default_nettype wire

// ===== rtl/multi_format_frame_detector_top.sv =====
// ----------------------------------------------------------------------------
// multi_format_frame_detector_top
// Collects serial bytes and emits fixed-length frames of one of nine formats.
// ----------------------------------------------------------------------------
// Each accepted byte is appended to the buffer. If check_now is set, the
// frame check follows; a matching frame is then sent byte by byte, each
// byte a store read and then a send, and the next byte is read only once
// the last one is taken, set by the single read port of the byte store and
// the output register; a stalled output holds the send. Input is stalled
// while a check or frame is in progress. Writing protocol_type with a new
// value empties the buffer.
`default_nettype none

module multi_format_frame_detector_top
  import mffd_pkg::*;
#(
  parameter int BUF_DEPTH = 256
)
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_check_now,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_frame_byte,
  output logic [LW-1:0]      out_frame_length,
  output logic               out_frame_last,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cmd_t       cmd;
  status_t    status;
  logic [3:0] proto;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_PROTO_TYPE);
  assign prdata = (paddr == REG_PROTO_TYPE) ? {28'd0, proto} : 32'd0;

  mffd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_check_now (in_check_now),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mffd_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_data_byte     (in_data_byte),
    .cfg_we           (cfg_we),
    .cfg_value        (pwdata[3:0]),
    .proto            (proto),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_frame_last   (out_frame_last)
  );

endmodule

`default_nettype wire

// ===== tb/mffd_frame_checker.sv =====
// ----------------------------------------------------------------------------
// mffd_frame_checker
// Watches the byte and frame channels of the multi-format frame detector,
// keeps its own copy of the byte buffer and selected format, works out the
// frame bytes each received byte should release and compares every frame
// byte leaving the block, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mffd_frame_checker
  import mffd_pkg::*;
#(
  parameter int         BUF_DEPTH  = 256,
  parameter logic [1:0] PROTO_ADDR = 2'd0
)
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_check_now,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire logic [7:0]    out_frame_byte,
  input  wire logic [LW-1:0] out_frame_length,
  input  wire logic          out_frame_last,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          pready,
  output int                 fail_count,
  output int                 due_count,
  output int                 frames_seen,
  output int                 bytes_seen
);

  localparam int VERDICT_WAIT = 0;
  localparam int VERDICT_DROP = -1;

  typedef struct {
    logic [7:0]    fbyte;
    logic [LW-1:0] flen;
    logic          flast;
  } frame_beat_t;

  frame_beat_t frame_bytes_due[$];
  logic [7:0]  held_bytes [0:BUF_DEPTH-1];
  int          held_cnt;
  logic [3:0]  fmt;
  int          fails;
  int          frames;
  int          beats;

  function automatic logic [7:0] hb(input int i);
    return held_bytes[i % BUF_DEPTH];
  endfunction

  function automatic bit st_a(input int n);
    return held_cnt == n && hb(0) == CH_S && hb(1) == CH_T && hb(n - 1) == CH_A;
  endfunction

  function automatic bit t_a(input int n);
    return held_cnt == n && hb(0) == CH_T && hb(n - 1) == CH_A;
  endfunction

  function automatic bit crlf_end(input int n);
    return hb(n - 2) == CH_CR && hb(n - 1) == CH_LF;
  endfunction

  function automatic int by_target(input int target);
    if (held_cnt == target) return target;
    return (held_cnt < target) ? VERDICT_WAIT : VERDICT_DROP;
  endfunction

  // frame length on a match, else wait or drop
  function automatic int frame_verdict();
    int         n;
    logic [7:0] h;
    n = held_cnt;
    h = hb(0);
    case (fmt)
      PROTO_HASH_PCT: begin
        if ((n == LEN_HASH && h == CH_HASH && crlf_end(LEN_HASH)) ||
            (n == LEN_PCT && h == CH_PCT && hb(POS_STAR) == CH_STAR && crlf_end(LEN_PCT)))
          return n;
        if ((h == CH_HASH && n < LEN_HASH) || (h == CH_PCT && n < LEN_PCT))
          return VERDICT_WAIT;
        return VERDICT_DROP;
      end
      PROTO_AV_CRLF: begin
        if (n == LEN_AV && (h == CH_A || h == CH_V) && crlf_end(LEN_AV)) return LEN_AV;
        return (n < LEN_AV) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_ST_16: begin
        if (st_a(17) || t_a(16)) return n;
        return (n < 16) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_ST_17: begin
        if (st_a(18) || t_a(17) || st_a(22) || t_a(21)) return n;
        return (n < 17) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_ST_14: begin
        if (st_a(15) || t_a(14)) return n;
        return (n < 14) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_PREFIX: begin
        if (n <= LEN_PREFIX) return VERDICT_WAIT;
        if (h == CH_B && hb(1) == CH_J && hb(2) == CH_T) return by_target(LEN_BJT);
        if (h == CH_S && hb(1) == CH_O && hb(2) == CH_E) return by_target(LEN_SOE);
        if (h == CH_E && hb(1) == CH_R && hb(2) == CH_R) return by_target(LEN_ERR);
        return VERDICT_DROP;
      end
      PROTO_EB90: begin
        if (n == LEN_EB90 && h == CH_EB && hb(1) == CH_90 && hb(LEN_EB90 - 1) == CH_FF)
          return LEN_EB90;
        return (n < LEN_EB90) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_AABB: begin
        if (n == LEN_AABB && h == CH_AA && hb(LEN_AABB - 1) == CH_BB) return LEN_AABB;
        return (n < LEN_AABB) ? VERDICT_WAIT : VERDICT_DROP;
      end
      PROTO_G_CRLF: begin
        if ((n == LEN_G_LONG && hb(1) == CH_G && crlf_end(LEN_G_LONG)) ||
            (n == LEN_G && hb(1) == CH_G && crlf_end(LEN_G)))
          return n;
        return (n < LEN_G) ? VERDICT_WAIT : VERDICT_DROP;
      end
      default: return VERDICT_WAIT;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    frame_beat_t want;
    frame_beat_t beat;
    int          v;
    if (!rst_n) begin
      frame_bytes_due.delete();
      for (int i = 0; i < BUF_DEPTH; i++) held_bytes[i] = 8'h00;
      held_cnt = 0;
      fmt      = PROTO_HASH_PCT;
      fails    = 0;
      frames   = 0;
      beats    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PROTO_ADDR) begin
        if (pwdata[3:0] != fmt) begin
          fmt      = pwdata[3:0];
          held_cnt = 0;
        end
      end

      if (out_valid && !out_stall) begin
        beats++;
        if (frame_bytes_due.size() == 0) begin
          fails++;
          $display("%0t: frame byte with none due, expected nothing got %02h",
                   $time, out_frame_byte);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_frame_byte !== want.fbyte) begin
            fails++;
            $display("%0t: frame_byte expected %02h got %02h",
                     $time, want.fbyte, out_frame_byte);
          end
          if (out_frame_length !== want.flen) begin
            fails++;
            $display("%0t: frame_length expected %0d got %0d",
                     $time, want.flen, out_frame_length);
          end
          if (out_frame_last !== want.flast) begin
            fails++;
            $display("%0t: frame_last expected %0b got %0b",
                     $time, want.flast, out_frame_last);
          end
        end
        if (out_frame_last === 1'b1) frames++;
      end

      if (in_valid && !in_stall) begin
        // full buffer restarts with the new byte
        if (held_cnt >= BUF_DEPTH - 1) held_cnt = 0;
        held_bytes[held_cnt] = in_data_byte;
        held_cnt++;
        if (in_check_now) begin
          v = frame_verdict();
          if (v == VERDICT_DROP) begin
            held_cnt = 0;
          end else if (v > 0) begin
            for (int k = 0; k < v; k++) begin
              beat.fbyte = hb(k);
              beat.flen  = LW'(v);
              beat.flast = (k == v - 1);
              frame_bytes_due.push_back(beat);
            end
            held_cnt = 0;
          end
        end
      end
    end
    fail_count  <= fails;
    due_count   <= frame_bytes_due.size();
    frames_seen <= frames;
    bytes_seen  <= beats;
  end

endmodule

`default_nettype wire

// ===== tb/multi_format_frame_detector_top_tb.sv =====
// ----------------------------------------------------------------------------
// multi_format_frame_detector_top_tb
// Drives received bytes into the frame detector under every format, with
// well-formed frames of random content, broken and overlong frames, noise,
// unknown formats and a buffer wrap, while both channels idle at random and
// the frame side holds off once for a long stretch. A checker beside the
// block predicts and compares every frame byte; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_format_frame_detector_top_tb;
  import mffd_pkg::*;

  localparam int         BUF_DEPTH      = 256;
  localparam logic [1:0] PROTO_ADDR     = 2'd0;
  localparam int         RAND_ITEMS     = 250;
  localparam int         HOLD_LEN       = 300;
  localparam int         SETTLE_CYCLES  = 6;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [3:0] PROTO_UNKNOWN  = 4'd15;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [7:0]    in_data_byte;
  logic          in_check_now;
  logic          out_valid;
  logic          out_stall;
  logic [7:0]    out_frame_byte;
  logic [LW-1:0] out_frame_length;
  logic          out_frame_last;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  int fail_count;
  int due_count;
  int frames_seen;
  int bytes_seen;

  logic [7:0] tx_bytes[$];
  int         items_sent;
  int         phases_run;
  int         idle_cycles;
  bit         no_gaps;
  bit         hold_go;

  multi_format_frame_detector_top #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_check_now     (in_check_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_frame_last   (out_frame_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  mffd_frame_checker #(
    .BUF_DEPTH  (BUF_DEPTH),
    .PROTO_ADDR (PROTO_ADDR)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_check_now     (in_check_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_frame_last   (out_frame_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .due_count        (due_count),
    .frames_seen      (frames_seen),
    .bytes_seen       (bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frame side: random stalls plus one long hold-off
  initial begin : frame_sink
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic c);
    while (!no_gaps && ($urandom_range(0, 99) < 31)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_check_now <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // sender pauses until no frame byte is due and the block has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_proto(input logic [3:0] v);
    logic [31:0] r;
    r = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PROTO_ADDR;
    pwdata  <= {r[31:4], v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_rand(input int n);
    repeat (n) tx_bytes.push_back(rnd8());
  endtask

  task automatic add_crlf();
    tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_LF);
  endtask

  task automatic add_hdr2(input logic [7:0] a, input logic [7:0] b);
    tx_bytes.push_back(a);
    tx_bytes.push_back(b);
  endtask

  // well-formed frame of the given format with random content; random bytes for an unknown format
  task automatic build_frame(input logic [3:0] p, input int variant);
    int v;
    v = (variant >= 0) ? variant : $urandom_range(0, 3);
    tx_bytes.delete();
    case (p)
      PROTO_HASH_PCT: begin
        if (v % 2 == 0) begin
          tx_bytes.push_back(CH_HASH);
          add_rand(LEN_HASH - 3);
        end else begin
          tx_bytes.push_back(CH_PCT);
          add_rand(POS_STAR - 1);
          tx_bytes.push_back(CH_STAR);
          add_rand(LEN_PCT - POS_STAR - 3);
        end
        add_crlf();
      end
      PROTO_AV_CRLF: begin
        tx_bytes.push_back((v % 2 == 0) ? CH_A : CH_V);
        add_rand(LEN_AV - 3);
        add_crlf();
      end
      PROTO_ST_16: begin
        if (v % 2 == 0) add_hdr2(CH_S, CH_T);
        else tx_bytes.push_back(CH_T);
        add_rand(14);
        tx_bytes.push_back(CH_A);
      end
      PROTO_ST_17: begin
        if (v % 2 == 0) add_hdr2(CH_S, CH_T);
        else tx_bytes.push_back(CH_T);
        add_rand((v < 2) ? 15 : 19);
        tx_bytes.push_back(CH_A);
      end
      PROTO_ST_14: begin
        if (v % 2 == 0) add_hdr2(CH_S, CH_T);
        else tx_bytes.push_back(CH_T);
        add_rand(12);
        tx_bytes.push_back(CH_A);
      end
      PROTO_PREFIX: begin
        case (v % 3)
          0: begin
            add_hdr2(CH_B, CH_J);
            tx_bytes.push_back(CH_T);
            add_rand(LEN_BJT - LEN_PREFIX);
          end
          1: begin
            add_hdr2(CH_S, CH_O);
            tx_bytes.push_back(CH_E);
            add_rand(LEN_SOE - LEN_PREFIX);
          end
          default: begin
            add_hdr2(CH_E, CH_R);
            tx_bytes.push_back(CH_R);
            add_rand(LEN_ERR - LEN_PREFIX);
          end
        endcase
      end
      PROTO_EB90: begin
        add_hdr2(CH_EB, CH_90);
        add_rand(LEN_EB90 - 3);
        tx_bytes.push_back(CH_FF);
      end
      PROTO_AABB: begin
        tx_bytes.push_back(CH_AA);
        add_rand(LEN_AABB - 2);
        tx_bytes.push_back(CH_BB);
      end
      PROTO_G_CRLF: begin
        add_hdr2(rnd8(), CH_G);
        add_rand(((v % 2 == 0) ? LEN_G : LEN_G_LONG) - 4);
        add_crlf();
      end
      default: add_rand($urandom_range(1, 30));
    endcase
  endtask

  // corrupt, truncate or overextend the frame in tx_bytes
  task automatic break_frame();
    case ($urandom_range(0, 2))
      0: tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = rnd8();
      1: void'(tx_bytes.pop_back());
      default: add_rand($urandom_range(1, 4));
    endcase
  endtask

  task automatic send_frame(input bit mid_checks);
    bit last;
    for (int i = 0; i < tx_bytes.size(); i++) begin
      last = (i == tx_bytes.size() - 1);
      put_byte(tx_bytes[i], last || (mid_checks && ($urandom_range(0, 7) == 0)));
    end
  endtask

  initial begin : stimulus
    logic [3:0] p;
    int         rand_start;
    int         nfr;
    int         kind;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_check_now <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= PROTO_ADDR;
    pwdata       <= 32'h0;
    items_sent   = 0;
    phases_run   = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    hold_go      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes in an AA..BB frame with an early check that waits
    write_proto(PROTO_AABB);
    put_byte(CH_AA, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(8'h01, 1'b1);
    put_byte(8'h80, 1'b0);
    put_byte(8'h7f, 1'b0);
    put_byte(8'h55, 1'b0);
    put_byte(8'hfe, 1'b0);
    put_byte(CH_BB, 1'b1);
    wait_quiet();

    // unknown format collects without matching or clearing
    write_proto(PROTO_UNKNOWN);
    repeat (4) put_byte(rnd8(), 1'b1);
    wait_quiet();

    // rewriting the same format keeps a partial frame
    write_proto(PROTO_AABB);
    put_byte(CH_AA, 1'b0);
    put_byte(8'h11, 1'b0);
    put_byte(8'h22, 1'b1);
    wait_quiet();
    write_proto(PROTO_AABB);
    put_byte(8'h33, 1'b0);
    put_byte(8'h44, 1'b0);
    put_byte(8'h55, 1'b0);
    put_byte(8'h66, 1'b0);
    put_byte(8'h77, 1'b0);
    put_byte(CH_BB, 1'b1);

    // random phases, one format per phase, every format in the first pass
    rand_start = items_sent;
    while (phases_run < 9 || items_sent - rand_start < RAND_ITEMS) begin
      if (phases_run < 9) p = phases_run[3:0];
      else if ($urandom_range(0, 7) == 0) p = 4'($urandom_range(9, 15));
      else p = 4'($urandom_range(0, 8));
      wait_quiet();
      no_gaps = (phases_run == 5 || phases_run == 6);
      write_proto(p);
      nfr = (phases_run == 2) ? 3 : $urandom_range(1, 3);
      if (phases_run == 2) hold_go = 1'b1;
      for (int f = 0; f < nfr; f++) begin
        kind = (phases_run == 2) ? 9 : $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 6)) put_byte(rnd8(), 1'($urandom_range(0, 1)));
        end else begin
          build_frame(p, (phases_run < 9 && f == 0 && p == PROTO_PREFIX) ? 0 : -1);
          if (kind == 1) break_frame();
          send_frame(1'b1);
        end
      end
      phases_run++;
    end
    no_gaps = 1'b0;

    // full buffer wrap: the frame starts on the byte that restarts the buffer
    wait_quiet();
    write_proto(PROTO_UNKNOWN);
    write_proto(PROTO_AABB);
    repeat (BUF_DEPTH - 1) put_byte(rnd8(), 1'b0);
    build_frame(PROTO_AABB, 0);
    send_frame(1'b0);

    wait_quiet();
    repeat (20) @(posedge clk);
    $display("covered %0d input bytes in %0d random phases plus directed and wrap parts",
             items_sent, phases_run);
    $display("checked %0d frames, %0d frame bytes, with one long output hold-off",
             frames_seen, bytes_seen);
    if (fail_count == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
